// ===== design/websocket_client_frame_encoder_assert.svh =====
// Assertion macros shared by the frame encoder modules.
`ifndef WEBSOCKET_CLIENT_FRAME_ENCODER_ASSERT_SVH
`define WEBSOCKET_CLIENT_FRAME_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define WCFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define WCFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define WCFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define WCFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/wcfe_pkg.sv =====
// Types and constants of the WebSocket client frame encoder.
`default_nettype none
package wcfe_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned STEP_W      = 4;

  localparam logic [7:0] OPCODE_TEXT = 8'h81;
  localparam logic [7:0] MASK_BIT    = 8'h80;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [STEP_W-1:0] HDR_LEN_SHORT = STEP_W'(6);
  localparam logic [STEP_W-1:0] HDR_LEN_MED   = STEP_W'(8);
  localparam logic [STEP_W-1:0] HDR_LEN_LONG  = STEP_W'(14);

  typedef enum logic [1:0] {
    LEN_SHORT = 2'd0,
    LEN_MED   = 2'd1,
    LEN_LONG  = 2'd2
  } len_kind_e;

  // One unit of work for the back end: an optional header burst and an
  // optional payload word, already masked.
  typedef struct packed {
    logic        has_hdr;
    len_kind_e   len_kind;
    logic [31:0] msg_length;
    logic [31:0] mask_key;
    logic        has_pay;
    logic [7:0]  pay_byte;
    logic        pay_last;
  } job_t;

endpackage
`default_nettype wire

// ===== design/wcfe_if.sv =====
// Input and output channel interfaces of the frame encoder.
`default_nettype none
interface wcfe_in_if;
  logic        valid;
  logic        ready;
  logic        start_req;
  logic [31:0] msg_length;
  logic [31:0] mask_key;
  logic        has_byte;
  logic [7:0]  data_byte;

  modport source (output valid, start_req, msg_length, mask_key, has_byte, data_byte,
                  input ready);
  modport sink (input valid, start_req, msg_length, mask_key, has_byte, data_byte,
                output ready);
endinterface

interface wcfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, out_byte, frame_end, input ready);
  modport sink (input valid, out_byte, frame_end, output ready);
endinterface
`default_nettype wire

// ===== design/wcfe_front.sv =====
// Front end: accepts input words, tracks frame state, builds jobs.
`default_nettype none
module wcfe_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  wcfe_in_if.sink            in_ch_i,
  input  wire logic          q_ready_i,
  output wcfe_pkg::job_t     job_o,
  output logic               push_o
);
  import wcfe_pkg::*;

  logic [31:0] left_q, left_d, left_s, left_dec;
  logic [31:0] mask_q, mask_d, mask_s;
  logic [1:0]  phase_q, phase_d, phase_s;
  logic        open_q, open_d, open_s;
  logic        accept, pay_ok, last;
  logic [7:0]  mask_sel;

  assign in_ch_i.ready = q_ready_i;
  assign accept = in_ch_i.valid && q_ready_i;

  always_comb begin
    // A start takes effect before the payload word of the same item.
    mask_s  = in_ch_i.start_req ? in_ch_i.mask_key : mask_q;
    left_s  = in_ch_i.start_req ? in_ch_i.msg_length : left_q;
    phase_s = in_ch_i.start_req ? 2'd0 : phase_q;
    open_s  = in_ch_i.start_req ? (in_ch_i.msg_length != 32'd0) : open_q;

    pay_ok   = in_ch_i.has_byte && open_s && (left_s != 32'd0);
    left_dec = left_s - 32'd1;
    last     = (left_dec == 32'd0);

    case (phase_s)
      2'd0:    mask_sel = mask_s[31:24];
      2'd1:    mask_sel = mask_s[23:16];
      2'd2:    mask_sel = mask_s[15:8];
      default: mask_sel = mask_s[7:0];
    endcase

    mask_d  = mask_s;
    left_d  = left_s;
    phase_d = phase_s;
    open_d  = open_s;
    if (pay_ok) begin
      left_d  = left_dec;
      phase_d = phase_s + 2'd1;
      open_d  = !last;
    end

    job_o.has_hdr    = in_ch_i.start_req;
    job_o.msg_length = in_ch_i.msg_length;
    job_o.mask_key   = in_ch_i.mask_key;
    if (in_ch_i.msg_length < 32'd126) begin
      job_o.len_kind = LEN_SHORT;
    end else if (in_ch_i.msg_length[31:16] == 16'd0) begin
      job_o.len_kind = LEN_MED;
    end else begin
      job_o.len_kind = LEN_LONG;
    end
    job_o.has_pay  = pay_ok;
    job_o.pay_byte = in_ch_i.data_byte ^ mask_sel;
    job_o.pay_last = last;

    // Drop items that produce no output word.
    push_o = accept && (in_ch_i.start_req || pay_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      mask_q  <= '0;
      phase_q <= '0;
      open_q  <= 1'b0;
    end else if (accept) begin
      left_q  <= left_d;
      mask_q  <= mask_d;
      phase_q <= phase_d;
      open_q  <= open_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/wcfe_queue.sv =====
// Job queue between the front and back ends.
`default_nettype none
`include "websocket_client_frame_encoder_assert.svh"
module wcfe_queue #(
  parameter int unsigned Depth = wcfe_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire wcfe_pkg::job_t job_i,
  output logic                ready_o,
  input  wire logic           pop_i,
  output wcfe_pkg::job_t      job_o,
  output logic                valid_o
);
  import wcfe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
    end
  end

  `WCFE_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, push_i, ready_o)
  `WCFE_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, pop_i, valid_o)
  `WCFE_ASSERT_NXT(a_cnt_grows, clk_i, rst_ni, push_i && !pop_i,
                   cnt_q == $past(cnt_q) + CntW'(1))

endmodule
`default_nettype wire

// ===== design/wcfe_back.sv =====
// Back end: serializes header, mask and payload words into the output register.
`default_nettype none
`include "websocket_client_frame_encoder_assert.svh"
module wcfe_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire wcfe_pkg::job_t job_i,
  input  wire logic           job_valid_i,
  output logic                pop_o,
  wcfe_out_if.source          out_ch_o
);
  import wcfe_pkg::*;

  typedef enum logic [1:0] {
    ST_HEAD = 2'b01,
    ST_DATA = 2'b10
  } back_state_e;

  back_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] hdr_len, ext_len, ext_idx, mask_idx;
  logic              out_valid_q;
  logic [7:0]        out_byte_q, byte_c, hdr_byte;
  logic              out_end_q, end_c;
  logic              load, emit_hdr, hdr_last;

  assign out_ch_o.valid     = out_valid_q;
  assign out_ch_o.out_byte  = out_byte_q;
  assign out_ch_o.frame_end = out_end_q;

  assign load = job_valid_i && (!out_valid_q || out_ch_o.ready);

  always_comb begin
    case (job_i.len_kind)
      LEN_SHORT: begin
        hdr_len = HDR_LEN_SHORT;
        ext_len = STEP_W'(0);
      end
      LEN_MED: begin
        hdr_len = HDR_LEN_MED;
        ext_len = STEP_W'(2);
      end
      default: begin
        hdr_len = HDR_LEN_LONG;
        ext_len = STEP_W'(8);
      end
    endcase
    ext_idx  = step_q - STEP_W'(2);
    mask_idx = step_q - STEP_W'(2) - ext_len;

    if (step_q == '0) begin
      hdr_byte = OPCODE_TEXT;
    end else if (step_q == STEP_W'(1)) begin
      case (job_i.len_kind)
        LEN_SHORT: hdr_byte = MASK_BIT | {1'b0, job_i.msg_length[6:0]};
        LEN_MED:   hdr_byte = MASK_BIT | {1'b0, LEN_CODE_16};
        default:   hdr_byte = MASK_BIT | {1'b0, LEN_CODE_64};
      endcase
    end else if (step_q < STEP_W'(2) + ext_len) begin
      // Extended length, big-endian; upper half of the 64-bit form is zero.
      if (job_i.len_kind == LEN_MED) begin
        hdr_byte = ext_idx[0] ? job_i.msg_length[7:0] : job_i.msg_length[15:8];
      end else if (ext_idx < STEP_W'(4)) begin
        hdr_byte = 8'h00;
      end else begin
        case (ext_idx[1:0])
          2'd0:    hdr_byte = job_i.msg_length[31:24];
          2'd1:    hdr_byte = job_i.msg_length[23:16];
          2'd2:    hdr_byte = job_i.msg_length[15:8];
          default: hdr_byte = job_i.msg_length[7:0];
        endcase
      end
    end else begin
      case (mask_idx[1:0])
        2'd0:    hdr_byte = job_i.mask_key[31:24];
        2'd1:    hdr_byte = job_i.mask_key[23:16];
        2'd2:    hdr_byte = job_i.mask_key[15:8];
        default: hdr_byte = job_i.mask_key[7:0];
      endcase
    end

    hdr_last = (step_q == hdr_len - STEP_W'(1));
    emit_hdr = (state_q == ST_HEAD) && job_i.has_hdr;
    byte_c   = emit_hdr ? hdr_byte : job_i.pay_byte;
    end_c    = emit_hdr ? (hdr_last && (job_i.msg_length == 32'd0)) : job_i.pay_last;

    state_d = state_q;
    step_d  = step_q;
    pop_o   = 1'b0;
    if (load) begin
      unique case (state_q)
        ST_HEAD: begin
          if (job_i.has_hdr) begin
            if (hdr_last) begin
              step_d = '0;
              if (job_i.has_pay) begin
                state_d = ST_DATA;
              end else begin
                pop_o = 1'b1;
              end
            end else begin
              step_d = step_q + STEP_W'(1);
            end
          end else begin
            pop_o = 1'b1;
          end
        end
        ST_DATA: begin
          pop_o   = 1'b1;
          state_d = ST_HEAD;
        end
        default: begin
          state_d = ST_HEAD;
          step_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HEAD;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_c;
      out_end_q  <= end_c;
    end
  end

  `WCFE_ASSERT_NOW(a_data_has_job, clk_i, rst_ni, state_q == ST_DATA,
                   job_valid_i && job_i.has_pay)
  `WCFE_ASSERT_NOW(a_step_in_head, clk_i, rst_ni, step_q != '0,
                   state_q == ST_HEAD && job_valid_i && job_i.has_hdr)
  `WCFE_ASSERT_NOW(a_pop_on_load, clk_i, rst_ni, pop_o, load)

endmodule
`default_nettype wire

// ===== design/websocket_client_frame_encoder.sv =====
// Top level of the masked WebSocket client text-frame encoder.
// Usage: an input word with start_req set opens a frame and yields the header
// burst (0x81, masked length with 16- or 64-bit extension, four mask bytes):
// 6, 8 or 14 output words for lengths below 126, below 65536 and above. Each
// payload word of an open frame yields one masked output word. The input side
// takes one word per clock while the job queue (QueueDepth entries) has room;
// the output side delivers one word per clock while out_ch_o.ready is high,
// so a run of payload words streams at that rate and a frame start costs its
// header length in output words, which the queue absorbs up to its depth. An
// input word crosses the queue memory, then the output register. frame_end
// marks the last word of each frame, the last mask byte for an empty frame.
`default_nettype none
module websocket_client_frame_encoder #(
  parameter int unsigned QueueDepth = wcfe_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wcfe_in_if.sink    in_ch_i,
  wcfe_out_if.source out_ch_o
);
  import wcfe_pkg::*;

  job_t push_job, head_job;
  logic push, q_ready, pop, head_valid;

  wcfe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch_i   (in_ch_i),
    .q_ready_i (q_ready),
    .job_o     (push_job),
    .push_o    (push)
  );

  wcfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .ready_o (q_ready),
    .pop_i   (pop),
    .job_o   (head_job),
    .valid_o (head_valid)
  );

  wcfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (head_valid),
    .pop_o       (pop),
    .out_ch_o    (out_ch_o)
  );

endmodule
`default_nettype wire
